FILE: rtl/damped_spring_force_unit_macros.svh
// Assertion macros for the damped spring force unit.
// Used by damped_spring_force_unit.sv; expects clk and rst_n in scope.
`ifndef DAMPED_SPRING_FORCE_UNIT_MACROS_SVH
`define DAMPED_SPRING_FORCE_UNIT_MACROS_SVH

// Same-cycle implication.
`define SFU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SFU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sfu_pkg.sv
// Package for the damped spring force unit: widths, register codes, payload structs.
// No dependencies; used by damped_spring_force_unit and its testbench.
`timescale 1ns / 1ps

package sfu_pkg;

  localparam int COORD_W      = 20;
  localparam int FRAC         = 10;
  localparam int FIELD_W      = 3 * COORD_W;
  localparam int IN_DATA_W    = 4 * FIELD_W;
  localparam int IN_USER_W    = 2;
  localparam int FORCE_W_DEF  = 32;

  localparam int STIFF_W      = 16;
  localparam int GAIN_W       = 16;
  localparam int REST_W       = 20;
  localparam int CFG_DATA_W   = 20;
  localparam int CFG_IDX_W    = 2;

  localparam int DW           = COORD_W + 1;
  localparam int SQ_W         = 2 * DW + 2;
  localparam int LEN_W        = SQ_W / 2;
  localparam int DOT_W        = 2 * DW + 2;
  localparam int HOOKE_W      = LEN_W + 1 + STIFF_W + 1;
  localparam int DNUM_W       = GAIN_W + 1 + DOT_W;
  localparam int Q1_W         = 39;
  localparam int DAMP_W       = Q1_W + 1;
  localparam int TOT_W        = ((HOOKE_W > DAMP_W) ? HOOKE_W : DAMP_W) + 1;
  localparam int PROD_W       = DW + TOT_W;
  localparam int DIV_SHIFT    = FRAC + 8 - 16;
  localparam int DEN2_W       = LEN_W + DIV_SHIFT;
  localparam int Q2_W         = 39;
  localparam int FRAW_W       = Q2_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPRING_ON    = 2'd0,
    REG_STIFFNESS    = 2'd1,
    REG_DAMPING_GAIN = 2'd2,
    REG_REST_LEN     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [DOT_W-1:0] dot;
    logic [2:0][DW-1:0]      d;
    logic                    free_a;
    logic                    free_b;
  } sq_pay_t;

  typedef struct packed {
    logic signed [HOOKE_W-1:0] hk;
    logic [LEN_W-1:0]          len;
    logic [2:0][DW-1:0]        d;
    logic                      dneg;
    logic                      zero;
    logic                      free_a;
    logic                      free_b;
  } div1_pay_t;

  typedef struct packed {
    logic zero;
    logic free_a;
    logic free_b;
    logic neg;
  } div2_pay_t;

endpackage

FILE: rtl/sfu_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on nothing; instantiated by damped_spring_force_unit.
`timescale 1ns / 1ps

module sfu_sqrt #(
  parameter int IN_W  = 44,
  parameter int PAY_W = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [IN_W-1:0]     radicand,
  input  logic [PAY_W-1:0]    pay,
  output logic                out_valid,
  output logic [IN_W/2-1:0]   root,
  output logic [PAY_W-1:0]    out_pay
);

  localparam int OUT_W = IN_W / 2;
  localparam int REM_W = OUT_W + 2;

  logic [OUT_W-1:0] vld_r;
  logic [REM_W-1:0] rem_r [OUT_W];
  logic [OUT_W-1:0] res_r [OUT_W];
  logic [IN_W-1:0]  x_r   [OUT_W];
  logic [PAY_W-1:0] pay_r [OUT_W];

  for (genvar k = 0; k < OUT_W; k++) begin : g_stage
    logic             v_in;
    logic [REM_W-1:0] rem_in;
    logic [OUT_W-1:0] res_in;
    logic [IN_W-1:0]  x_in;
    logic [PAY_W-1:0] pay_in;
    logic [REM_W+1:0] shifted;
    logic [REM_W+1:0] trial;
    logic             take;

    if (k == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = '0;
      assign res_in = '0;
      assign x_in   = radicand;
      assign pay_in = pay;
    end else begin : g_next
      assign v_in   = vld_r[k-1];
      assign rem_in = rem_r[k-1];
      assign res_in = res_r[k-1];
      assign x_in   = x_r[k-1];
      assign pay_in = pay_r[k-1];
    end

    assign shifted = {rem_in, x_in[IN_W-1:IN_W-2]};
    assign trial   = (REM_W + 2)'({res_in, 2'b01});
    assign take    = shifted >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= take ? REM_W'(shifted - trial) : REM_W'(shifted);
        res_r[k] <= {res_in[OUT_W-2:0], take};
        x_r[k]   <= {x_in[IN_W-3:0], 2'b00};
        pay_r[k] <= pay_in;
      end
    end
  end

  assign out_valid = vld_r[OUT_W-1];
  assign root      = res_r[OUT_W-1];
  assign out_pay   = pay_r[OUT_W-1];

endmodule

FILE: rtl/sfu_div.sv
// Pipelined restoring divider for unsigned magnitudes, one quotient bit per stage.
// Caller guarantees the quotient fits QUO_W bits. Used by damped_spring_force_unit.
`timescale 1ns / 1ps

module sfu_div #(
  parameter int NUM_W = 61,
  parameter int DEN_W = 22,
  parameter int QUO_W = 39,
  parameter int PAY_W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [PAY_W-1:0] pay,
  output logic             out_valid,
  output logic [QUO_W-1:0] quo,
  output logic [PAY_W-1:0] out_pay
);

  logic [QUO_W-1:0] vld_r;
  logic [DEN_W-1:0] rem_r [QUO_W];
  logic [QUO_W-1:0] low_r [QUO_W];
  logic [DEN_W-1:0] den_r [QUO_W];
  logic [PAY_W-1:0] pay_r [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic             v_in;
    logic [DEN_W-1:0] rem_in;
    logic [QUO_W-1:0] low_in;
    logic [DEN_W-1:0] den_in;
    logic [PAY_W-1:0] pay_in;
    logic [DEN_W:0]   top;
    logic             take;

    if (k == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = DEN_W'(num[NUM_W-1:QUO_W]);
      assign low_in = num[QUO_W-1:0];
      assign den_in = den;
      assign pay_in = pay;
    end else begin : g_next
      assign v_in   = vld_r[k-1];
      assign rem_in = rem_r[k-1];
      assign low_in = low_r[k-1];
      assign den_in = den_r[k-1];
      assign pay_in = pay_r[k-1];
    end

    assign top  = {rem_in, low_in[QUO_W-1]};
    assign take = top >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= take ? DEN_W'(top - {1'b0, den_in}) : DEN_W'(top);
        low_r[k] <= {low_in[QUO_W-2:0], take};
        den_r[k] <= den_in;
        pay_r[k] <= pay_in;
      end
    end
  end

  assign out_valid = vld_r[QUO_W-1];
  assign quo       = low_r[QUO_W-1];
  assign out_pay   = pay_r[QUO_W-1];

endmodule

FILE: rtl/damped_spring_force_unit.sv
// Damped spring force unit top level: stream ports, config registers, pipeline.
// Depends on sfu_pkg, sfu_sqrt, sfu_div and damped_spring_force_unit_macros.svh.
`timescale 1ns / 1ps
`include "damped_spring_force_unit_macros.svh"

// Takes one spring per clock while in_tready is high and returns the force
// increments on both particles; the depth comes from the bit-per-stage square
// root (22 stages) and two restoring dividers in series (39 stages each). When
// out_tready is low the pipeline keeps moving until a finished result waits in
// the output register and a second one has reached the last divider stage; only
// then does in_tready drop, and it follows out_tready in the same cycle. Config
// writes are taken every cycle and should only be issued while no transaction is
// in flight.
module damped_spring_force_unit #(
  parameter int FORCE_WIDTH = sfu_pkg::FORCE_W_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // tdata: pos_first, pos_second, vel_first, vel_second
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sfu_pkg::IN_DATA_W-1:0]   in_tdata,
  // tuser: free_first, free_second
  input  logic [sfu_pkg::IN_USER_W-1:0]   in_tuser,
  // tdata: force_a_x, force_a_y, force_a_z, force_b_x, force_b_y, force_b_z
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [((6*FORCE_WIDTH+7)/8)*8-1:0] out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sfu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sfu_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int FW         = FORCE_WIDTH;
  localparam int OUT_DATA_W = ((6 * FW + 7) / 8) * 8;
  localparam int CW         = sfu_pkg::COORD_W;
  localparam int DW         = sfu_pkg::DW;
  localparam int FLD        = sfu_pkg::FIELD_W;
  localparam int LEN_W      = sfu_pkg::LEN_W;
  localparam int FR_W       = sfu_pkg::FRAW_W;

  // Config registers
  logic                         spring_on_r;
  logic [sfu_pkg::STIFF_W-1:0]  stiffness_r;
  logic [sfu_pkg::GAIN_W-1:0]   damping_gain_r;
  logic [sfu_pkg::REST_W-1:0]   rest_len_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spring_on_r    <= 1'b1;
      stiffness_r    <= sfu_pkg::STIFF_W'(256);
      damping_gain_r <= '0;
      rest_len_r     <= '0;
    end else if (cfg_valid) begin
      unique case (sfu_pkg::cfg_reg_t'(cfg_index))
        sfu_pkg::REG_SPRING_ON:    spring_on_r    <= cfg_data[0];
        sfu_pkg::REG_STIFFNESS:    stiffness_r    <= cfg_data[sfu_pkg::STIFF_W-1:0];
        sfu_pkg::REG_DAMPING_GAIN: damping_gain_r <= cfg_data[sfu_pkg::GAIN_W-1:0];
        sfu_pkg::REG_REST_LEN:     rest_len_r     <= cfg_data[sfu_pkg::REST_W-1:0];
        default: ;
      endcase
    end
  end

  // Flow control
  logic out_tvalid_r;
  logic out_load;
  logic pipe_en;
  logic d2_valid;

  assign out_load  = !out_tvalid_r || out_tready;
  assign pipe_en   = !d2_valid || out_load;
  assign in_tready = pipe_en;

  // Stage 1: differences
  logic                 v1_r;
  logic signed [DW-1:0] d_s1_r  [3];
  logic signed [DW-1:0] rv_s1_r [3];
  logic                 fa_s1_r, fb_s1_r;
  logic signed [DW-1:0] d_s1_nxt  [3];
  logic signed [DW-1:0] rv_s1_nxt [3];

  always_comb begin
    logic signed [CW-1:0] pa, pb, va, vb;
    for (int i = 0; i < 3; i++) begin
      pa = in_tdata[i*CW +: CW];
      pb = in_tdata[FLD + i*CW +: CW];
      va = in_tdata[2*FLD + i*CW +: CW];
      vb = in_tdata[3*FLD + i*CW +: CW];
      d_s1_nxt[i]  = signed'({pa[CW-1], pa}) - signed'({pb[CW-1], pb});
      rv_s1_nxt[i] = signed'({va[CW-1], va}) - signed'({vb[CW-1], vb});
    end
  end

  // Stage 2: products
  logic                     v2_r;
  logic signed [2*DW-1:0]   sq_s2_r [3];
  logic signed [2*DW-1:0]   dp_s2_r [3];
  logic signed [DW-1:0]     d_s2_r  [3];
  logic                     fa_s2_r, fb_s2_r;

  // Stage 3: sums
  logic                               v3_r;
  logic [sfu_pkg::SQ_W-1:0]           sq_s3_r;
  logic signed [sfu_pkg::DOT_W-1:0]   dot_s3_r;
  logic signed [DW-1:0]               d_s3_r [3];
  logic                               fa_s3_r, fb_s3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (pipe_en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) begin
        d_s1_r[i]  <= d_s1_nxt[i];
        rv_s1_r[i] <= rv_s1_nxt[i];
        sq_s2_r[i] <= d_s1_r[i] * d_s1_r[i];
        dp_s2_r[i] <= d_s1_r[i] * rv_s1_r[i];
        d_s2_r[i]  <= d_s1_r[i];
        d_s3_r[i]  <= d_s2_r[i];
      end
      fa_s1_r  <= in_tuser[0];
      fb_s1_r  <= in_tuser[1];
      fa_s2_r  <= fa_s1_r;
      fb_s2_r  <= fb_s1_r;
      fa_s3_r  <= fa_s2_r;
      fb_s3_r  <= fb_s2_r;
      sq_s3_r  <= sfu_pkg::SQ_W'(unsigned'(sq_s2_r[0])) +
                  sfu_pkg::SQ_W'(unsigned'(sq_s2_r[1])) +
                  sfu_pkg::SQ_W'(unsigned'(sq_s2_r[2]));
      dot_s3_r <= sfu_pkg::DOT_W'(dp_s2_r[0]) + sfu_pkg::DOT_W'(dp_s2_r[1]) +
                  sfu_pkg::DOT_W'(dp_s2_r[2]);
    end
  end

  // Square root
  sfu_pkg::sq_pay_t sq_pay_in, sq_pay_out;
  logic             sq_valid;
  logic [LEN_W-1:0] len_sq;

  always_comb begin
    sq_pay_in.dot    = dot_s3_r;
    for (int i = 0; i < 3; i++) sq_pay_in.d[i] = d_s3_r[i];
    sq_pay_in.free_a = fa_s3_r;
    sq_pay_in.free_b = fb_s3_r;
  end

  sfu_sqrt #(
    .IN_W  (sfu_pkg::SQ_W),
    .PAY_W ($bits(sfu_pkg::sq_pay_t))
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (v3_r),
    .radicand  (sq_s3_r),
    .pay       (sq_pay_in),
    .out_valid (sq_valid),
    .root      (len_sq),
    .out_pay   (sq_pay_out)
  );

  // Stage 4: Hooke product and damping numerator
  logic                               v4_r;
  logic signed [sfu_pkg::HOOKE_W-1:0] hk_s4_r;
  logic signed [sfu_pkg::DNUM_W-1:0]  dn_s4_r;
  logic [LEN_W-1:0]                   len_s4_r;
  logic [2:0][DW-1:0]                 d_s4_r;
  logic                               fa_s4_r, fb_s4_r;
  logic signed [LEN_W:0]              stretch;

  assign stretch = signed'({1'b0, len_sq}) -
                   signed'((LEN_W + 1)'(rest_len_r));

  // Stage 5: magnitude for the first divide
  logic                              v5_r;
  logic [sfu_pkg::DNUM_W-1:0]        dmag_s5_r;
  sfu_pkg::div1_pay_t                p5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (pipe_en) begin
      v4_r <= sq_valid;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      hk_s4_r   <= stretch * signed'({1'b0, stiffness_r});
      dn_s4_r   <= signed'({1'b0, damping_gain_r}) * sq_pay_out.dot;
      len_s4_r  <= len_sq;
      d_s4_r    <= sq_pay_out.d;
      fa_s4_r   <= sq_pay_out.free_a;
      fb_s4_r   <= sq_pay_out.free_b;
      dmag_s5_r <= dn_s4_r[sfu_pkg::DNUM_W-1] ? unsigned'(-dn_s4_r) : unsigned'(dn_s4_r);
      p5_r.hk     <= hk_s4_r;
      p5_r.len    <= len_s4_r;
      p5_r.d      <= d_s4_r;
      p5_r.dneg   <= dn_s4_r[sfu_pkg::DNUM_W-1];
      p5_r.zero   <= len_s4_r == '0;
      p5_r.free_a <= fa_s4_r;
      p5_r.free_b <= fb_s4_r;
    end
  end

  // Damping divide
  logic                    d1_valid;
  logic [sfu_pkg::Q1_W-1:0] q1;
  sfu_pkg::div1_pay_t      p1;

  sfu_div #(
    .NUM_W (sfu_pkg::DNUM_W),
    .DEN_W (LEN_W),
    .QUO_W (sfu_pkg::Q1_W),
    .PAY_W ($bits(sfu_pkg::div1_pay_t))
  ) u_div_damp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (v5_r),
    .num       (dmag_s5_r),
    .den       (p5_r.len),
    .pay       (p5_r),
    .out_valid (d1_valid),
    .quo       (q1),
    .out_pay   (p1)
  );

  // Stage 6: total scalar force
  logic                              v6_r;
  logic signed [sfu_pkg::TOT_W-1:0]  tot_s6_r;
  logic [LEN_W-1:0]                  len_s6_r;
  logic [2:0][DW-1:0]                d_s6_r;
  logic                              z6_r, fa_s6_r, fb_s6_r;
  logic signed [sfu_pkg::DAMP_W-1:0] damp_q;
  logic signed [sfu_pkg::DAMP_W-1:0] damp;

  assign damp_q = signed'({1'b0, q1});
  assign damp   = p1.dneg ? damp_q : -damp_q;

  // Stage 7: axis products
  logic                              v7_r;
  logic signed [sfu_pkg::PROD_W-1:0] pr_s7_r [3];
  logic [LEN_W-1:0]                  len_s7_r;
  logic                              z7_r, fa_s7_r, fb_s7_r;

  // Stage 8: magnitudes for the axis divides
  logic                              v8_r;
  logic [sfu_pkg::PROD_W-1:0]        pm_s8_r [3];
  logic [sfu_pkg::DEN2_W-1:0]        den_s8_r;
  sfu_pkg::div2_pay_t                p8_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else if (pipe_en) begin
      v6_r <= d1_valid;
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      tot_s6_r <= sfu_pkg::TOT_W'(damp) - sfu_pkg::TOT_W'(p1.hk);
      len_s6_r <= p1.len;
      d_s6_r   <= p1.d;
      z6_r     <= p1.zero;
      fa_s6_r  <= p1.free_a;
      fb_s6_r  <= p1.free_b;
      len_s7_r <= len_s6_r;
      z7_r     <= z6_r;
      fa_s7_r  <= fa_s6_r;
      fb_s7_r  <= fb_s6_r;
      den_s8_r <= {len_s7_r, {sfu_pkg::DIV_SHIFT{1'b0}}};
      for (int i = 0; i < 3; i++) begin
        pr_s7_r[i]     <= signed'(d_s6_r[i]) * tot_s6_r;
        pm_s8_r[i]     <= pr_s7_r[i][sfu_pkg::PROD_W-1] ? unsigned'(-pr_s7_r[i])
                                                        : unsigned'(pr_s7_r[i]);
        p8_r[i].neg    <= pr_s7_r[i][sfu_pkg::PROD_W-1];
        p8_r[i].zero   <= z7_r;
        p8_r[i].free_a <= fa_s7_r;
        p8_r[i].free_b <= fb_s7_r;
      end
    end
  end

  // Axis divides
  logic [2:0]               d2_vld;
  logic [sfu_pkg::Q2_W-1:0] q2 [3];
  sfu_pkg::div2_pay_t       p2 [3];

  for (genvar i = 0; i < 3; i++) begin : g_axis
    sfu_div #(
      .NUM_W (sfu_pkg::PROD_W),
      .DEN_W (sfu_pkg::DEN2_W),
      .QUO_W (sfu_pkg::Q2_W),
      .PAY_W ($bits(sfu_pkg::div2_pay_t))
    ) u_div_axis (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (pipe_en),
      .in_valid  (v8_r),
      .num       (pm_s8_r[i]),
      .den       (den_s8_r),
      .pay       (p8_r[i]),
      .out_valid (d2_vld[i]),
      .quo       (q2[i]),
      .out_pay   (p2[i])
    );
  end

  assign d2_valid = &d2_vld;

  // Output stage: sign, saturate, negate, mask
  logic signed [FW-1:0] fa_sat [3];
  logic signed [FW-1:0] fb_neg [3];
  logic signed [FW-1:0] fa_out_nxt [3];
  logic signed [FW-1:0] fb_out_nxt [3];
  logic signed [FW-1:0] fa_r [3];
  logic signed [FW-1:0] fb_r [3];

  localparam logic signed [FW-1:0] F_MAX = {1'b0, {(FW-1){1'b1}}};
  localparam logic signed [FW-1:0] F_MIN = {1'b1, {(FW-1){1'b0}}};

  for (genvar i = 0; i < 3; i++) begin : g_sat
    logic signed [FR_W-1:0] fq;
    logic signed [FR_W-1:0] fraw;

    assign fq   = signed'({1'b0, q2[i]});
    assign fraw = p2[i].zero ? '0 : (p2[i].neg ? -fq : fq);

    if (FW >= FR_W) begin : g_wide
      assign fa_sat[i] = FW'(fraw);
    end else begin : g_narrow
      logic signed [FR_W-1:0] lim_hi, lim_lo;
      assign lim_hi = FR_W'(F_MAX);
      assign lim_lo = FR_W'(F_MIN);
      always_comb begin
        priority if (fraw > lim_hi) fa_sat[i] = F_MAX;
        else if (fraw < lim_lo)     fa_sat[i] = F_MIN;
        else                        fa_sat[i] = FW'(fraw);
      end
    end

    assign fb_neg[i]     = (fa_sat[i] == F_MIN) ? F_MAX : -fa_sat[i];
    assign fa_out_nxt[i] = (spring_on_r && p2[i].free_a) ? fa_sat[i] : '0;
    assign fb_out_nxt[i] = (spring_on_r && p2[i].free_b) ? fb_neg[i] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int i = 0; i < 3; i++) begin
        fa_r[i] <= fa_out_nxt[i];
        fb_r[i] <= fb_out_nxt[i];
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_DATA_W'({fb_r[2], fb_r[1], fb_r[0], fa_r[2], fa_r[1], fa_r[0]});

  // Checks
  `SFU_ASSERT_NOW(a_stall_only_on_backpressure, !in_tready,
    out_tvalid && !out_tready, "input stalled without output backpressure")
  `SFU_ASSERT_NOW(a_spring_off_zero, out_tvalid && !spring_on_r,
    out_tdata == '0, "nonzero force with spring disabled")
  `SFU_ASSERT_NEXT(a_fixed_a_zero, pipe_en && d2_valid && !p2[0].free_a,
    fa_r[0] == '0 && fa_r[1] == '0 && fa_r[2] == '0, "force on fixed particle a")

endmodule

FILE: test/damped_spring_force_unit_tb.sv
// Testbench for damped_spring_force_unit: directed and random springs, stream checking.
// Depends on sfu_pkg and the damped_spring_force_unit RTL.
`timescale 1ns / 1ps

module damped_spring_force_unit_tb;

  localparam int FW = 32;
  localparam int OUT_W = ((6 * FW + 7) / 8) * 8;
  localparam int LATENCY = 109;
  localparam int WD_LIMIT = 20000;

  typedef struct packed {
    logic [sfu_pkg::FIELD_W-1:0] pa, pb, va, vb;
    logic fa, fb;
  } spring_t;

  typedef struct {
    sfu_pkg::cfg_reg_t idx;
    logic [sfu_pkg::CFG_DATA_W-1:0] val;
  } cfg_wr_t;

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, in_tready;
  logic [sfu_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic [sfu_pkg::IN_USER_W-1:0] in_tuser = '0;
  logic out_tvalid, out_tready = 0;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_valid = 0, cfg_ready;
  logic [sfu_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sfu_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  damped_spring_force_unit #(.FORCE_WIDTH(FW)) DUT (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  logic m_on;
  logic [15:0] m_stiff, m_gain;
  logic [19:0] m_rest;

  spring_t pending_springs[$];
  logic [OUT_W-1:0] expected_forces[$];
  cfg_wr_t pending_cfg[$];
  int send_idle_pct = 0, recv_idle_pct = 0;
  bit hold_off = 0;
  int mismatches = 0;
  int idle_cycles = 0;

  function automatic longint comp(logic [sfu_pkg::FIELD_W-1:0] p, int i);
    logic signed [sfu_pkg::COORD_W-1:0] c;
    c = p[i*sfu_pkg::COORD_W +: sfu_pkg::COORD_W];
    return longint'(c);
  endfunction

  function automatic longint isqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [OUT_W-1:0] spring_force(spring_t s);
    longint d[3], rv[3], fa[3], fb[3];
    longint unsigned sq;
    longint dot, len, hooke, damp, total, dv;
    logic [OUT_W-1:0] r;
    r = '0;
    sq = 0;
    dot = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = comp(s.pa, i) - comp(s.pb, i);
      rv[i] = comp(s.va, i) - comp(s.vb, i);
      fa[i] = 0;
      sq += longint'(d[i] * d[i]);
      dot += d[i] * rv[i];
    end
    if (m_on && (s.fa || s.fb)) begin
      len = isqrt(sq);
      if (len != 0) begin
        hooke = -((len - longint'(m_rest)) * longint'(m_stiff));
        damp = -((longint'(m_gain) * dot) / len);
        total = hooke + damp;
        dv = len * (64'sd1 << (sfu_pkg::FRAC + 8 - 16));
        for (int i = 0; i < 3; i++) fa[i] = clamp32((d[i] * total) / dv);
      end
    end
    for (int i = 0; i < 3; i++) begin
      fb[i] = clamp32(-fa[i]);
      if (!m_on || !s.fa) fa[i] = 0;
      if (!m_on || !s.fb) fb[i] = 0;
      r[i*FW +: FW] = fa[i][FW-1:0];
      r[(3+i)*FW +: FW] = fb[i][FW-1:0];
    end
    return r;
  endfunction

  // driver: springs and config writes
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) cfg_valid <= 0;
      else if (!cfg_valid && pending_cfg.size() > 0) begin
        cfg_index <= pending_cfg[0].idx;
        cfg_data <= pending_cfg[0].val;
        cfg_valid <= 1;
        void'(pending_cfg.pop_front());
      end
      if (in_tvalid && in_tready) begin
        void'(pending_springs.pop_front());
        in_tvalid <= 0;
      end
      if ((!in_tvalid || in_tready) && pending_springs.size() > 0) begin
        if ($urandom_range(99) >= send_idle_pct) begin
          spring_t s;
          s = pending_springs[0];
          in_tdata <= {s.vb, s.va, s.pb, s.pa};
          in_tuser <= {s.fb, s.fa};
          in_tvalid <= 1;
        end
      end
    end
  end

  // expectation on acceptance, checking and receiver idling
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        spring_t s;
        s.pa = in_tdata[0 +: sfu_pkg::FIELD_W];
        s.pb = in_tdata[sfu_pkg::FIELD_W +: sfu_pkg::FIELD_W];
        s.va = in_tdata[2*sfu_pkg::FIELD_W +: sfu_pkg::FIELD_W];
        s.vb = in_tdata[3*sfu_pkg::FIELD_W +: sfu_pkg::FIELD_W];
        s.fa = in_tuser[0];
        s.fb = in_tuser[1];
        expected_forces.push_back(spring_force(s));
      end
      if (out_tvalid && out_tready) begin
        if (expected_forces.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_tdata);
        end else begin
          logic [OUT_W-1:0] e;
          e = expected_forces.pop_front();
          for (int f = 0; f < 6; f++)
            if (e[f*FW +: FW] !== out_tdata[f*FW +: FW]) begin
              mismatches++;
              if (mismatches <= 10)
                $display("force field %0d: expected %h got %h", f, e[f*FW +: FW],
                         out_tdata[f*FW +: FW]);
            end
        end
      end
      out_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WD_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(sfu_pkg::cfg_reg_t idx, logic [sfu_pkg::CFG_DATA_W-1:0] val);
    cfg_wr_t w;
    w.idx = idx;
    w.val = val;
    pending_cfg.push_back(w);
    while (pending_cfg.size() > 0 || cfg_valid) @(posedge clk);
    @(posedge clk);
    unique case (idx)
      sfu_pkg::REG_SPRING_ON: m_on = val[0];
      sfu_pkg::REG_STIFFNESS: m_stiff = val[15:0];
      sfu_pkg::REG_DAMPING_GAIN: m_gain = val[15:0];
      sfu_pkg::REG_REST_LEN: m_rest = val[19:0];
    endcase
  endtask

  task automatic drain();
    while (pending_springs.size() > 0 || in_tvalid || expected_forces.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic [sfu_pkg::COORD_W-1:0] rnd_coord();
    case ($urandom_range(5))
      0: return 20'h7FFFF;
      1: return 20'h80000;
      2: return sfu_pkg::COORD_W'($urandom_range(0, 63) - 32);
      default: return sfu_pkg::COORD_W'($urandom);
    endcase
  endfunction

  function automatic logic [sfu_pkg::FIELD_W-1:0] rnd_vec();
    return {rnd_coord(), rnd_coord(), rnd_coord()};
  endfunction

  task automatic add_random(int n);
    spring_t s;
    repeat (n) begin
      s.pa = rnd_vec();
      s.pb = ($urandom_range(15) == 0) ? s.pa : rnd_vec();
      s.va = rnd_vec();
      s.vb = rnd_vec();
      s.fa = ($urandom_range(7) != 0);
      s.fb = ($urandom_range(7) != 0);
      pending_springs.push_back(s);
    end
  endtask

  task automatic random_cfg();
    write_reg(sfu_pkg::REG_SPRING_ON, sfu_pkg::CFG_DATA_W'($urandom_range(5) != 0));
    write_reg(sfu_pkg::REG_STIFFNESS, sfu_pkg::CFG_DATA_W'(
      $urandom_range(3) == 0 ? 32'hFFFF : $urandom_range(0, 2047)));
    write_reg(sfu_pkg::REG_DAMPING_GAIN, sfu_pkg::CFG_DATA_W'(
      $urandom_range(3) == 0 ? 32'hFFFF : $urandom_range(0, 1023)));
    write_reg(sfu_pkg::REG_REST_LEN, sfu_pkg::CFG_DATA_W'(
      $urandom_range(3) == 0 ? 32'hFFFFF : $urandom_range(0, 8191)));
  endtask

  initial begin
    spring_t s;
    m_on = 1;
    m_stiff = 256;
    m_gain = 0;
    m_rest = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reset config, extremes, zero length, fixed particles
    s = '0;
    s.fa = 1;
    s.fb = 1;
    pending_springs.push_back(s);
    s.pa = {20'h7FFFF, 20'h7FFFF, 20'h7FFFF};
    s.pb = {20'h80000, 20'h80000, 20'h80000};
    s.va = {3{20'h7FFFF}};
    s.vb = {3{20'h80000}};
    pending_springs.push_back(s);
    s.fa = 0;
    pending_springs.push_back(s);
    s.fa = 1;
    s.fb = 0;
    pending_springs.push_back(s);
    s.fa = 0;
    pending_springs.push_back(s);
    s.fa = 1;
    s.fb = 1;
    s.pa = {3{20'h00400}};
    s.pb = s.pa;
    pending_springs.push_back(s);
    s.pa = {40'h0, 20'h00C00};
    s.pb = '0;
    pending_springs.push_back(s);
    drain();
    write_reg(sfu_pkg::REG_STIFFNESS, 20'h0FFFF);
    write_reg(sfu_pkg::REG_DAMPING_GAIN, 20'h0FFFF);
    write_reg(sfu_pkg::REG_REST_LEN, 20'hFFFFF);
    add_random(8);
    drain();
    write_reg(sfu_pkg::REG_SPRING_ON, '0);
    add_random(4);
    drain();
    write_reg(sfu_pkg::REG_SPRING_ON, 20'd1);
    write_reg(sfu_pkg::REG_STIFFNESS, '0);
    write_reg(sfu_pkg::REG_DAMPING_GAIN, '0);
    write_reg(sfu_pkg::REG_REST_LEN, '0);
    add_random(4);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 51 : 0;
      recv_idle_pct = (ph == 0) ? 51 : (ph == 1) ? 25 : 0;
      for (int k = 0; k < 5; k++) begin
        random_cfg();
        add_random(100);
        if (ph == 2 && k == 0) begin
          hold_off = 1;
          repeat (400) @(posedge clk);
          hold_off = 0;
        end
        drain();
      end
    end

    if (mismatches == 0 && expected_forces.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule

FILE: files.f
+incdir+rtl
rtl/sfu_pkg.sv
rtl/sfu_sqrt.sv
rtl/sfu_div.sv
rtl/damped_spring_force_unit.sv
test/damped_spring_force_unit_tb.sv
